[hdl/ple_pkg.sv]
// Package for the positional list engine: request and status codes,
// fixed field widths and the command word that is broadcast to the cells.
// No dependencies.
package ple_pkg;

    localparam int REQ_TYPE_W    = 2;
    localparam int POSITION_W    = 7;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 7;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_READ   = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_DELETE = 2'd2
    } req_type_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Command broadcast to every cell in the row for one cycle
    typedef struct packed {
        logic                      ins;
        logic                      del;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

[hdl/ple_if.sv]
// Valid/ready channels of the positional list engine: request and response.
// Depends on ple_pkg for field widths.
interface ple_req_if
    import ple_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [REQ_TYPE_W-1:0]        req_type;
    logic [POSITION_W-1:0]        position;
    logic signed [VALUE_W-1:0]    insert_value;

    modport source (output valid, output req_type, output position,
                    output insert_value, input ready);
    modport sink   (input valid, input req_type, input position,
                    input insert_value, output ready);
endinterface

interface ple_rsp_if
    import ple_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic [STATUS_W-1:0]          status;
    logic signed [VALUE_W-1:0]    read_value;
    logic [ENTRY_COUNT_W-1:0]     entry_count;

    modport source (output valid, output status, output read_value,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input read_value,
                    input entry_count, output ready);
endinterface

[hdl/positional_list_engine.sv]
// Positional list engine: ordered list of signed 32-bit entries in a row of cells.
// The response is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle while the response is taken; every cell shifts in the same cycle.
// Reset clears the entry count and the response valid flag; entries stay undefined
// until written and are never read before that.
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    ple_req_if.sink   req,
    ple_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;

    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [VALUE_W-1:0] read_value_reg;
    logic [ENTRY_COUNT_W-1:0]  entry_count_reg;

    status_t                   status_next;
    logic signed [VALUE_W-1:0] rd_next;
    logic signed [VALUE_W-1:0] hit_any;
    cell_cmd_t                 cmd;
    logic [CMP_W-1:0]          pos_ext;
    logic [CMP_W-1:0]          cnt_ext;
    logic [CMP_W-1:0]          idx;
    logic                      pos_nz;
    logic                      in_list;
    logic                      full;
    logic                      req_accept;

    logic signed [VALUE_W-1:0] cell_q   [LIST_DEPTH];
    logic signed [VALUE_W-1:0] cell_hit [LIST_DEPTH];

    // Take a new item whenever the response register is free or draining
    assign req.ready  = !out_valid_reg || rsp.ready;
    assign req_accept = req.valid && req.ready;

    assign pos_ext = CMP_W'(req.position);
    assign cnt_ext = CMP_W'(count_reg);
    assign idx     = pos_ext - CMP_W'(1);
    assign pos_nz  = (req.position != '0);
    assign in_list = pos_nz && (pos_ext <= cnt_ext);
    assign full    = (count_reg == CNT_W'(LIST_DEPTH));

    // Row of cells, each tied to its two neighbors
    for (genvar i = 0; i < LIST_DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_d;
        logic signed [VALUE_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_q[i-1];
        end

        if (i == LIST_DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_q[i+1];
        end

        ple_cell #(
            .INDEX (i),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .idx        (idx),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_q[i]),
            .hit_data   (cell_hit[i])
        );
    end

    // Merge the one matching cell's entry
    always_comb
    begin
        hit_any = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            hit_any = hit_any | cell_hit[i];
        end
    end

    // Decode the request, check range and fullness, drive the cell command
    always_comb
    begin
        status_next = ST_RANGE;
        rd_next     = '0;
        count_next  = count_reg;
        cmd.ins     = 1'b0;
        cmd.del     = 1'b0;
        cmd.value   = req.insert_value;
        case (req_type_t'(req.req_type))
            REQ_READ:
            begin
                if (in_list)
                begin
                    status_next = ST_DONE;
                    rd_next     = hit_any;
                end
            end
            REQ_INSERT:
            begin
                if (pos_nz && (pos_ext <= cnt_ext + CMP_W'(1)))
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        status_next = ST_DONE;
                        cmd.ins     = req_accept;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
            end
            REQ_DELETE:
            begin
                if (in_list)
                begin
                    status_next = ST_DONE;
                    cmd.del     = req_accept;
                    count_next  = count_reg - CNT_W'(1);
                end
            end
            default:
            begin
                status_next = ST_RANGE;
            end
        endcase
    end

    // Hold the count and the valid flag of the response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the response payload
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            status_reg      <= status_next;
            read_value_reg  <= rd_next;
            entry_count_reg <= ENTRY_COUNT_W'(count_next);
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule

[hdl/ple_cell.sv]
// One list cell: holds the entry at a fixed slot and shifts with its neighbors.
// Depends on ple_pkg for the command word.
module ple_cell
    import ple_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CMP_W = 8
) (
    input  logic                      clk,
    input  cell_cmd_t                 cmd,
    input  logic [CMP_W-1:0]          idx,
    input  logic signed [VALUE_W-1:0] left_data,
    input  logic signed [VALUE_W-1:0] right_data,
    output logic signed [VALUE_W-1:0] data,
    output logic signed [VALUE_W-1:0] hit_data
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic signed [VALUE_W-1:0] entry_reg;
    logic signed [VALUE_W-1:0] entry_next;

    // Pick the new entry: shift up behind an insert, take the value at it,
    // shift down from the deleted slot onward
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.ins && (MY_IDX > idx))
        begin
            entry_next = left_data;
        end
        else if (cmd.ins && (MY_IDX == idx))
        begin
            entry_next = cmd.value;
        end
        else if (cmd.del && (MY_IDX >= idx))
        begin
            entry_next = right_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign data     = entry_reg;
    assign hit_data = (MY_IDX == idx) ? entry_reg : '0;

endmodule

[hdl/ple_checker.sv]
// Port-level checks for the positional list engine, bound to the top level.
// Depends on ple_pkg for status codes and field widths.
module ple_checker
    import ple_pkg::*;
#(
    parameter int LIST_DEPTH = 64
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [STATUS_W-1:0]       status,
    input logic signed [VALUE_W-1:0] read_value,
    input logic [ENTRY_COUNT_W-1:0]  entry_count
);

    localparam logic [ENTRY_COUNT_W-1:0] DEPTH_CNT = ENTRY_COUNT_W'(LIST_DEPTH);

    // Hold a response until it is taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // Answer every accepted request in the next cycle
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> rsp_valid)
        else $error("no response after accepted request");

    // Report full only when the list holds every entry
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_FULL) |-> (entry_count == DEPTH_CNT))
        else $error("full status with spare room");

    // Return zero data on any failed request
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_DONE) |-> (read_value == '0))
        else $error("nonzero read value on failed request");

endmodule

bind positional_list_engine ple_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_ple_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req.valid),
    .req_ready   (req.ready),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .read_value  (rsp.read_value),
    .entry_count (rsp.entry_count)
);

[tb/positional_list_engine_tb.sv]
// Testbench for the positional list engine: directed table, then biased random requests.
// Each response is checked against an in-bench list predictor or a fixed table result.
// Depends on ple_pkg, ple_if and positional_list_engine.
module positional_list_engine_tb;
    import ple_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH = 64;
    localparam int N_BLOCKS   = 10;
    localparam int BLOCK_LEN  = 145;

    // Request code that the block does not define
    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    // Operation mix of a random block
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    typedef struct packed {
        status_t                     status;
        logic signed [VALUE_W-1:0]   read_value;
        logic [ENTRY_COUNT_W-1:0]    entry_count;
    } list_result_t;

    typedef struct packed {
        logic [REQ_TYPE_W-1:0]       kind;
        logic [POSITION_W-1:0]       position;
        logic signed [VALUE_W-1:0]   value;
        logic                        fixed;
        list_result_t                result;
    } dir_row_t;

    logic clk;
    logic rst_n;

    ple_req_if req_ch ();
    ple_rsp_if rsp_ch ();

    positional_list_engine #(
        .LIST_DEPTH (LIST_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the list
    logic signed [VALUE_W-1:0] shadow_entries [LIST_DEPTH];
    int                        shadow_count;

    list_result_t pending_results [$];
    dir_row_t     dir_rows [$];
    int           mismatch_count;
    int           src_idle_pct;
    int           snk_stall_pct;

    // Clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Apply one request to the shadow list and return its response
    function automatic list_result_t apply_request(input logic [REQ_TYPE_W-1:0] kind,
                                                   input logic [POSITION_W-1:0] position,
                                                   input logic signed [VALUE_W-1:0] value);
        list_result_t res;
        int           pos;
        int           k;
        pos = int'(position);
        res.status     = ST_RANGE;
        res.read_value = '0;
        case (kind)
            REQ_READ:
            begin
                if (pos >= 1 && pos <= shadow_count)
                begin
                    res.read_value = shadow_entries[pos-1];
                    res.status     = ST_DONE;
                end
            end
            REQ_INSERT:
            begin
                // Range is checked before fullness
                if (pos >= 1 && pos <= shadow_count + 1)
                begin
                    if (shadow_count >= LIST_DEPTH)
                        res.status = ST_FULL;
                    else
                    begin
                        for (k = shadow_count; k > pos - 1; k--)
                            shadow_entries[k] = shadow_entries[k-1];
                        shadow_entries[pos-1] = value;
                        shadow_count++;
                        res.status = ST_DONE;
                    end
                end
            end
            REQ_DELETE:
            begin
                if (pos >= 1 && pos <= shadow_count)
                begin
                    for (k = pos - 1; k + 1 < shadow_count; k++)
                        shadow_entries[k] = shadow_entries[k+1];
                    shadow_count--;
                    res.status = ST_DONE;
                end
            end
            default:
                res.status = ST_RANGE;
        endcase
        res.entry_count = ENTRY_COUNT_W'(shadow_count);
        return res;
    endfunction

    // Drive one item, hold it until accepted, record its expected response.
    // Called at a falling edge; returns at a falling edge with valid still high.
    task automatic issue_request(input logic [REQ_TYPE_W-1:0] kind,
                                 input logic [POSITION_W-1:0] position,
                                 input logic signed [VALUE_W-1:0] value,
                                 input logic fixed,
                                 input list_result_t fixed_result);
        list_result_t predicted;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.position     <= position;
        req_ch.insert_value <= value;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = apply_request(kind, position, value);
        pending_results.push_back(fixed ? fixed_result : predicted);
        @(negedge clk);
    endtask

    task automatic add_row(input logic [REQ_TYPE_W-1:0] kind, input int position,
                           input logic signed [VALUE_W-1:0] value, input logic fixed,
                           input status_t status, input logic signed [VALUE_W-1:0] read_value,
                           input int entry_count);
        dir_row_t row;
        row.kind                   = kind;
        row.position               = POSITION_W'(position);
        row.value                  = value;
        row.fixed                  = fixed;
        row.result.status          = status;
        row.result.read_value      = read_value;
        row.result.entry_count     = ENTRY_COUNT_W'(entry_count);
        dir_rows.push_back(row);
    endtask

    // Position mostly inside the valid range, sometimes at its edges or anywhere
    function automatic logic [POSITION_W-1:0] pick_position(input logic [REQ_TYPE_W-1:0] kind);
        int limit;
        int r;
        limit = (kind == REQ_INSERT) ? shadow_count + 1 : shadow_count;
        r = $urandom_range(0, 99);
        if (r < 80 && limit >= 1)
            return POSITION_W'($urandom_range(1, limit));
        else if (r < 90)
        begin
            case ($urandom_range(0, 2))
                0:       return '0;
                1:       return POSITION_W'(limit);
                default: return POSITION_W'(limit + 1);
            endcase
        end
        return POSITION_W'($urandom_range(0, 127));
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 99) < 70)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            3:       return -1;
            default: return 1;
        endcase
    endfunction

    task automatic run_block(input int count, input int mix);
        int                    n;
        int                    r;
        int                    ins_lim;
        int                    del_lim;
        int                    rd_lim;
        logic [REQ_TYPE_W-1:0] kind;
        list_result_t          none;
        none = '0;
        case (mix)
            MIX_FILL:  begin ins_lim = 65; del_lim = 75; rd_lim = 96; end
            MIX_DRAIN: begin ins_lim = 10; del_lim = 75; rd_lim = 96; end
            default:   begin ins_lim = 35; del_lim = 65; rd_lim = 95; end
        endcase
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_lim)
                kind = REQ_INSERT;
            else if (r < del_lim)
                kind = REQ_DELETE;
            else if (r < rd_lim)
                kind = REQ_READ;
            else
                kind = REQ_UNKNOWN;
            issue_request(kind, pick_position(kind), pick_value(), 1'b0, none);
        end
    endtask

    // Receiver stalls
    always @(negedge clk)
        rsp_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    // Check each response against the oldest expectation
    always @(posedge clk)
    begin
        list_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%t: response with none expected: status %0d value %0d count %0d",
                             $realtime, rsp_ch.status, rsp_ch.read_value, rsp_ch.entry_count);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status || rsp_ch.read_value !== want.read_value
                    || rsp_ch.entry_count !== want.entry_count)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%t: mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
                                 $realtime, want.status, want.read_value, want.entry_count,
                                 rsp_ch.status, rsp_ch.read_value, rsp_ch.entry_count);
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int           blk;
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_READ;
        req_ch.position     = '0;
        req_ch.insert_value = '0;
        rsp_ch.ready        = 1'b0;
        shadow_count        = 0;
        mismatch_count      = 0;
        src_idle_pct        = 21;
        snk_stall_pct       = 21;
        foreach (shadow_entries[i])
            shadow_entries[i] = '0;

        // Empty list, bad positions, extremes, front, middle and end insertion
        add_row(REQ_READ,    1,   0,            1'b1, ST_RANGE, 0,       0);
        add_row(REQ_DELETE,  1,   0,            1'b1, ST_RANGE, 0,       0);
        add_row(REQ_READ,    0,   0,            1'b1, ST_RANGE, 0,       0);
        add_row(REQ_INSERT,  0,   5,            1'b1, ST_RANGE, 0,       0);
        add_row(REQ_INSERT,  2,   5,            1'b1, ST_RANGE, 0,       0);
        add_row(REQ_INSERT,  1,   VAL_MIN,      1'b1, ST_DONE,  0,       1);
        add_row(REQ_INSERT,  2,   VAL_MAX,      1'b1, ST_DONE,  0,       2);
        add_row(REQ_READ,    1,   0,            1'b1, ST_DONE,  VAL_MIN, 2);
        add_row(REQ_READ,    2,   0,            1'b1, ST_DONE,  VAL_MAX, 2);
        add_row(REQ_READ,    3,   0,            1'b1, ST_RANGE, 0,       2);
        add_row(REQ_INSERT,  1,   0,            1'b1, ST_DONE,  0,       3);
        add_row(REQ_INSERT,  2,   -1,           1'b0, ST_DONE,  0,       0);
        add_row(REQ_INSERT,  5,   1,            1'b0, ST_DONE,  0,       0);
        add_row(REQ_INSERT,  7,   9,            1'b1, ST_RANGE, 0,       5);
        add_row(REQ_UNKNOWN, 1,   VAL_MAX,      1'b1, ST_RANGE, 0,       5);
        add_row(REQ_READ,    127, 0,            1'b1, ST_RANGE, 0,       5);
        add_row(REQ_DELETE,  127, 0,            1'b1, ST_RANGE, 0,       5);
        add_row(REQ_INSERT,  127, 32'h5555_5555, 1'b1, ST_RANGE, 0,      5);
        add_row(REQ_READ,    3,   0,            1'b0, ST_DONE,  0,       0);
        add_row(REQ_DELETE,  1,   0,            1'b0, ST_DONE,  0,       0);
        add_row(REQ_DELETE,  4,   0,            1'b0, ST_DONE,  0,       0);
        add_row(REQ_READ,    2,   0,            1'b0, ST_DONE,  0,       0);
        add_row(REQ_DELETE,  0,   0,            1'b1, ST_RANGE, 0,       3);
        add_row(REQ_INSERT,  3,   32'hAAAA_AAAA, 1'b0, ST_DONE, 0,       0);
        add_row(REQ_READ,    4,   0,            1'b0, ST_DONE,  0,       0);

        // Hold reset, then release it
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table
        foreach (dir_rows[i])
            issue_request(dir_rows[i].kind, dir_rows[i].position, dir_rows[i].value,
                          dir_rows[i].fixed, dir_rows[i].result);

        // Random blocks, each after a drain of all outstanding responses
        for (blk = 0; blk < N_BLOCKS; blk++)
        begin
            req_ch.valid <= 1'b0;
            do
                @(negedge clk);
            while (pending_results.size() != 0);
            case (blk % 4)
                0:       begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1:       begin src_idle_pct = 72; snk_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  snk_stall_pct = 72; end
                default: begin src_idle_pct = 21; snk_stall_pct = 21; end
            endcase
            run_block(BLOCK_LEN, blk % 3);
        end

        // Drain and finish
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("positional_list_engine_tb OK");
        else
            $display("positional_list_engine_tb NOT OK");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20_000_000;
        $display("positional_list_engine_tb NOT OK");
        $finish;
    end

endmodule
